FILE: rtl/core/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 7;
    // Position tags wrap modulo twice the deepest window.
    localparam int POS_W        = $clog2(2 * WINDOW_MAX);
    localparam int NCELLS       = WINDOW_MAX;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [POS_W-1:0]               pos_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
        pos_t    pos;
    } entry_t;

    // Shared control for every cell of the candidate chain.
    typedef struct packed {
        logic    load;
        logic    shift;
        logic    flush;
        logic    insert;
        sample_t sample;
        pos_t    pos;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  swm_pkg::entry_t    right,
    input  logic               left_keep,
    output swm_pkg::entry_t    entry,
    output swm_pkg::entry_t    entry_next,
    output logic               keep
);
    import swm_pkg::*;

    logic    valid_reg;
    sample_t value_reg;
    pos_t    pos_reg;
    entry_t  own;
    entry_t  src;
    logic    ins;

    assign own = '{valid: valid_reg, value: value_reg, pos: pos_reg};
    assign entry = own;

    always_comb
    begin
        if (ctrl.flush)
        begin
            src = '0;
        end
        else if (ctrl.shift)
        begin
            src = right;
        end
        else
        begin
            src = own;
        end
    end

    // Candidates strictly smaller than the new sample are evicted; equal ones stay.
    assign keep = src.valid && !(ctrl.insert && (src.value < ctrl.sample));
    // The queue is a prefix of the chain, so the new sample lands where the kept run ends.
    assign ins  = ctrl.insert && left_keep && !keep;

    always_comb
    begin
        entry_next.valid = keep || ins;
        entry_next.value = keep ? src.value : ctrl.sample;
        entry_next.pos   = keep ? src.pos : ctrl.pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= entry_next.value;
            pos_reg   <= entry_next.pos;
        end
    end

endmodule

FILE: rtl/core/sliding_window_maximum_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                   Contents
// s_*       in         tvalid tready tdata tuser tdata: sample; tuser: first_of_sequence
// m_*       out        tvalid tready tdata       tdata: window_max
// cfg_*     in         we wdata                  window_length
//
// One sample is taken per cycle while the result register is free or being drained
// and no second stale candidate waits. Once the window is full, a sample's result
// appears in the cycle after it is taken. After the window is shortened, each stale
// candidate beyond the first stalls input, as the chain drops one head entry per cycle.
// Reset empties the candidate chain, clears the counters and sets the window to 1.

module sliding_window_maximum_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [swm_pkg::SAMPLE_WIDTH-1:0]     s_tdata,   // [15:0] sample
    input  logic                                 s_tuser,   // [0] first_of_sequence
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [swm_pkg::SAMPLE_WIDTH-1:0]     m_tdata,   // [15:0] window_max
    input  logic                                 cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]            cfg_wdata
);
    import swm_pkg::*;

    logic [CFG_W-1:0] wlen_reg;
    pos_t             pos_reg;
    pos_t             seen_reg;
    logic             m_valid_reg;
    sample_t          m_data_reg;

    pos_t             eff_w;
    pos_t             p;
    pos_t             head_age;
    pos_t             base_seen;
    pos_t             seen_next;
    logic             step;
    logic             first;
    logic             drop;
    logic             stale1;
    cell_ctrl_t       ctrl;
    entry_t           ent      [NCELLS];
    entry_t           ent_next [NCELLS];
    logic             keep     [NCELLS];
    logic [NCELLS-1:0] valid_vec;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_w = pos_t'(1);
        end
        else if (POS_W'(wlen_reg) > pos_t'(WINDOW_MAX))
        begin
            eff_w = pos_t'(WINDOW_MAX);
        end
        else
        begin
            eff_w = POS_W'(wlen_reg);
        end
    end

    assign first    = s_tuser;
    assign p        = first ? '0 : pos_reg;
    assign head_age = p - ent[0].pos;
    // A second stale candidate only exists after the window was shortened.
    assign stale1   = ent[1].valid && ((pos_reg - ent[1].pos) >= eff_w);
    assign s_tready = !stale1 && (!m_valid_reg || m_tready);
    assign step     = s_tvalid && s_tready;
    assign drop     = !first && ent[0].valid && (head_age >= eff_w);

    always_comb
    begin
        ctrl.load   = step || stale1;
        ctrl.shift  = stale1 || drop;
        ctrl.flush  = step && first;
        ctrl.insert = step;
        ctrl.sample = sample_t'(s_tdata);
        ctrl.pos    = p;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++)
        begin : g_cell
            entry_t right_in;
            logic   left_in;
            if (gi == NCELLS - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid
                assign right_in = ent[gi+1];
            end
            if (gi == 0)
            begin : g_head
                assign left_in = 1'b1;
            end
            else
            begin : g_body
                assign left_in = keep[gi-1];
            end
            swm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .right      (right_in),
                .left_keep  (left_in),
                .entry      (ent[gi]),
                .entry_next (ent_next[gi]),
                .keep       (keep[gi])
            );
            assign valid_vec[gi] = ent[gi].valid;
        end
    endgenerate

    assign base_seen = first ? '0 : seen_reg;
    assign seen_next = (base_seen < eff_w) ? base_seen + pos_t'(1) : eff_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg    <= CFG_W'(1);
            pos_reg     <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
            end
            if (step)
            begin
                pos_reg     <= p + pos_t'(1);
                seen_reg    <= seen_next;
                m_valid_reg <= (seen_next >= eff_w);
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_data_reg <= ent_next[0].value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> ent[0].valid)
        else $error("candidate head empty after a request");

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + NCELLS'(1))) == '0)
        else $error("candidate chain has a hole");

    a_first_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (step && first) |=> (seen_reg == pos_t'(1)))
        else $error("sample count not restarted");

    a_head_age: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> ((pos_reg - ent[0].pos) <= $past(eff_w)))
        else $error("head candidate older than the window");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import swm_pkg::*;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
    typedef enum int {SHAPE_UNIFORM, SHAPE_NARROW, SHAPE_FALLING, SHAPE_RISING, SHAPE_WALK}
        shape_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [CFG_W-1:0] length;
        sample_t          sample;
        logic             first;
        logic             typed;
        sample_t          typed_max;
    } plan_row_t;

    typedef struct packed {
        sample_t value;
        pos_t    tag;
    } candidate_t;

    localparam int PLAN_ROWS    = 29;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD    = 300;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Shadow copy of the block's window state.
    logic [CFG_W-1:0] window_setting = 7'd1;
    candidate_t       candidates[$];
    pos_t             next_tag = '0;
    int unsigned      fill_count = 0;

    sample_t          expected_max[$];
    int               mismatch_count = 0;
    int               accepted_samples = 0;
    int               burst_left = 0;
    bit               sender_gaps_on = 1'b1;
    bit               long_hold_done = 1'b0;

    plan_row_t        plan [PLAN_ROWS];

    sliding_window_maximum_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Steps the shadow deque by one sample; returns 1 when the window is full.
    function automatic bit next_window_max(input sample_t s, input logic first,
                                           output sample_t peak);
        int unsigned span;
        pos_t        tag;
        pos_t        age;
        candidate_t  fresh;
        span = (window_setting == 0) ? 1 :
               (window_setting > WINDOW_MAX) ? WINDOW_MAX : window_setting;
        if (first)
        begin
            candidates.delete();
            next_tag   = '0;
            fill_count = 0;
        end
        tag = next_tag;
        while (candidates.size() > 0)
        begin
            age = tag - candidates[0].tag;
            if (age < span)
                break;
            candidates.delete(0);
        end
        while (candidates.size() > 0 && candidates[$].value < s)
            candidates.delete(candidates.size() - 1);
        if (candidates.size() < WINDOW_MAX)
        begin
            fresh.value = s;
            fresh.tag   = tag;
            candidates.insert(candidates.size(), fresh);
        end
        fill_count = (fill_count < span) ? fill_count + 1 : span;
        next_tag   = tag + 1'b1;
        peak = '0;
        if (fill_count >= span && candidates.size() > 0)
        begin
            peak = candidates[0].value;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_sample(input sample_t s, input logic first, input logic typed,
                               input sample_t typed_max);
        int      gap;
        sample_t peak;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = !sender_gaps_on ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        accepted_samples++;
        if (next_window_max(s, first, peak))
            expected_max.insert(expected_max.size(), typed ? typed_max : peak);
    endtask

    // Stops the sender and lets every outstanding result drain.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_max.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] length);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= length;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_setting = length;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_max.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected window max: expected none, actual %0d",
                         $time, $signed(m_tdata));
            end
            else
            begin
                if (m_tdata !== expected_max[0])
                begin
                    mismatch_count++;
                    $display("%0t: window max mismatch: expected %0d, actual %0d",
                             $time, expected_max[0], $signed(m_tdata));
                end
                expected_max.delete(0);
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and once holds off for a long
    // stretch so the result register fills and the input side backs up.
    initial
    begin
        int mode;
        int stretch;
        int phase;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            for (int i = 0; i < stretch; i++)
            begin
                if (!long_hold_done && accepted_samples >= 600)
                begin
                    long_hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        phase = i % 3;
                        m_tready <= (phase != 0);
                    end
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int               random_items;
        int               pick;
        int               phase_len;
        int               level;
        int unsigned      span;
        logic [CFG_W-1:0] length;
        logic             restart;
        logic             first;
        shape_t           shape;

        // Window 1 rows read straight off the input; zero length behaves as 1.
        // Lengths above the deepest window clamp to it.
        plan = '{
            '{ROW_WINDOW, 7'd1,   16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b1, 1'b1, 16'h8000},
            '{ROW_SAMPLE, 7'd0,   16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{ROW_SAMPLE, 7'd0,   16'h0000, 1'b0, 1'b1, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
            '{ROW_SAMPLE, 7'd0,   16'h0001, 1'b1, 1'b1, 16'h0001},
            '{ROW_WINDOW, 7'd0,   16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h5555, 1'b0, 1'b1, 16'h5555},
            '{ROW_SAMPLE, 7'd0,   16'hAAAA, 1'b0, 1'b1, 16'hAAAA},
            '{ROW_WINDOW, 7'd4,   16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0003, 1'b1, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0003, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'hFFFB, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0007, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0007, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0002, 1'b0, 1'b0, 16'h0000},
            '{ROW_WINDOW, 7'd2,   16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h8001, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'hFFFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h7FFE, 1'b0, 1'b0, 16'h0000},
            '{ROW_WINDOW, 7'd6,   16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0010, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0020, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h0030, 1'b0, 1'b0, 16'h0000},
            '{ROW_WINDOW, 7'd127, 16'h0000, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h1234, 1'b1, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b0, 1'b0, 16'h0000}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WINDOW)
                write_window(plan[i].length);
            else
                push_sample(plan[i].sample, plan[i].first, plan[i].typed, plan[i].typed_max);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: length = 7'd1;
                1: length = 7'd64;
                2: length = ($urandom_range(0, 1) == 0) ? 7'd127 :
                            CFG_W'($urandom_range(65, 126));
                3: length = 7'd0;
                4, 5, 6, 7: length = CFG_W'($urandom_range(2, 8));
                default: length = CFG_W'($urandom_range(9, 40));
            endcase
            write_window(length);
            span = (length == 0) ? 1 : (length > WINDOW_MAX) ? WINDOW_MAX : length;
            phase_len = (span >= 32) ? $urandom_range(80, 180) : $urandom_range(20, 120);
            // Without a restart the new length applies to the running sequence.
            restart = ($urandom_range(0, 1) == 0);
            shape = shape_t'($urandom_range(0, 4));
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            case (shape)
                SHAPE_FALLING: level = 32767 - $urandom_range(0, 200);
                SHAPE_RISING:  level = -32768 + $urandom_range(0, 200);
                default:       level = $signed(16'($urandom));
            endcase
            for (int k = 0; k < phase_len; k++)
            begin
                first = (k == 0 && restart) || ($urandom_range(0, 59) == 0);
                case (shape)
                    SHAPE_UNIFORM: level = $urandom_range(0, 65535);
                    SHAPE_NARROW:  level = $urandom_range(0, 6) - 3;
                    SHAPE_FALLING: level = level - $urandom_range(0, 3);
                    SHAPE_RISING:  level = level + $urandom_range(0, 3);
                    default:       level = level + $urandom_range(0, 40) - 20;
                endcase
                push_sample(sample_t'(level), first, 1'b0, '0);
                random_items++;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_max.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
